// ===== hdl/usbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// usbpd_pkg
// Shared types, codes and helpers of the USB PD sink policy engine.
// ----------------------------------------------------------------------------
package usbpd_pkg;

  // Stream and configuration port widths
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_TUSER_W = 1;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_CAPS_TMO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENDER_RESP_TMO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PS_TRANS_TMO    = 2'd2;

  localparam logic [15:0] WAIT_CAPS_TMO_RST   = 16'd465;
  localparam logic [15:0] SENDER_RESP_TMO_RST = 16'd500;
  localparam logic [15:0] PS_TRANS_TMO_RST    = 16'd500;

  typedef enum logic [2:0] {
    PE_IDLE        = 3'd0,
    PE_WAIT_CAPS   = 3'd1,
    PE_WAIT_ACCEPT = 3'd2,
    PE_WAIT_PSRDY  = 3'd3,
    PE_READY       = 3'd4,
    PE_ERROR       = 3'd5
  } policy_state_t;

  typedef enum logic [1:0] {
    OP_ATTACH  = 2'd0,
    OP_DETACH  = 2'd1,
    OP_MESSAGE = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  // PD message types (header bits 4:0)
  localparam logic [4:0] MT_SRC_CAPS = 5'h01;
  localparam logic [4:0] MT_REQUEST  = 5'h02;
  localparam logic [4:0] MT_ACCEPT   = 5'h03;
  localparam logic [4:0] MT_REJECT   = 5'h04;
  localparam logic [4:0] MT_PS_RDY   = 5'h06;
  localparam logic [4:0] MT_WAIT     = 5'h0C;

  localparam logic [1:0]  SPEC_REV_30 = 2'b10;
  localparam logic [15:0] REQ_HEADER  =
      16'(MT_REQUEST) | (16'(SPEC_REV_30) << 6) | (16'd1 << 12);

  localparam logic [5:0] VOLT_UNIT_MV = 6'd50;
  localparam logic [3:0] CURR_UNIT_MA = 4'd10;

  typedef struct packed {
    op_t         operation;
    logic        sop_is_sop;
    logic [15:0] header;
    logic [2:0]  obj_count;
    logic [31:0] first_object;
    logic        transmit_ok;
  } item_t;

  typedef struct packed {
    policy_state_t policy_state;
    logic          request_valid;
    logic [15:0]   request_header;
    logic [31:0]   request_object;
    logic [15:0]   contract_voltage_mv;
    logic [13:0]   contract_current_ma;
  } result_t;

  // Fixed-supply RDO: position 1, no USB suspend, USB comms capable,
  // operating and max current both at the PDO's max current.
  function automatic logic [31:0] fixed_rdo(input logic [9:0] units);
    fixed_rdo = {3'b000, 1'b1, 2'b00, 2'b11, 4'b0000, units, units};
  endfunction

  function automatic logic [15:0] volt_mv(input logic [9:0] units);
    volt_mv = 16'({6'd0, units} * 16'(VOLT_UNIT_MV));
  endfunction

  function automatic logic [13:0] curr_ma(input logic [9:0] units);
    curr_ma = 14'({4'd0, units} * 14'(CURR_UNIT_MA));
  endfunction

endpackage

// ===== hdl/usbpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// usbpd_in_stage
// Input register: unpacks the slave stream word and holds it for the engine.
// ----------------------------------------------------------------------------
module usbpd_in_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [usbpd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [usbpd_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                              advance,
  output logic                              item_vld,
  output usbpd_pkg::item_t                  item
);
  import usbpd_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  take;

  assign in_tready = !vld_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    item_nxt.operation    = op_t'(in_tuser);
    item_nxt.sop_is_sop   = in_tdata[0];
    item_nxt.header       = in_tdata[16:1];
    item_nxt.obj_count    = in_tdata[19:17];
    item_nxt.first_object = in_tdata[51:20];
    item_nxt.transmit_ok  = in_tdata[52];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== hdl/usbpd_engine.sv =====
// ----------------------------------------------------------------------------
// usbpd_engine
// Policy state, timeout registers and the per-word state update.
// ----------------------------------------------------------------------------
module usbpd_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [usbpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [usbpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                              step_en,
  input  usbpd_pkg::item_t                  item,
  output usbpd_pkg::result_t                result
);
  import usbpd_pkg::*;

  logic [15:0] caps_tmo_r;
  logic [15:0] resp_tmo_r;
  logic [15:0] ps_tmo_r;

  policy_state_t state_r;
  policy_state_t state_nxt;
  logic [15:0]   elapsed_r;
  logic [15:0]   elapsed_nxt;
  logic [19:0]   pdo_r;
  logic [19:0]   pdo_nxt;
  logic [15:0]   volt_r;
  logic [15:0]   volt_nxt;
  logic [13:0]   curr_r;
  logic [13:0]   curr_nxt;

  logic [15:0] elapsed_inc;
  logic [4:0]  hdr_type;
  logic        is_data;
  logic        caps_hit;
  logic        req_send;

  assign hdr_type    = item.header[4:0];
  assign is_data     = (item.obj_count != 3'd0);
  assign elapsed_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign caps_hit    = (item.operation == OP_MESSAGE) && item.sop_is_sop && is_data &&
                       (state_r == PE_WAIT_CAPS) && (hdr_type == MT_SRC_CAPS);
  assign req_send    = caps_hit && (item.first_object[31:30] == 2'b00) &&
                       item.transmit_ok;

  // Next state
  always_comb begin
    state_nxt   = state_r;
    elapsed_nxt = elapsed_r;
    pdo_nxt     = pdo_r;
    volt_nxt    = volt_r;
    curr_nxt    = curr_r;
    case (item.operation)
      OP_ATTACH, OP_DETACH: begin
        state_nxt   = (item.operation == OP_ATTACH) ? PE_WAIT_CAPS : PE_IDLE;
        elapsed_nxt = '0;
        pdo_nxt     = '0;
        volt_nxt    = '0;
        curr_nxt    = '0;
      end
      OP_MESSAGE: begin
        if (caps_hit) begin
          pdo_nxt = item.first_object[19:0];
          if (req_send) begin
            state_nxt   = PE_WAIT_ACCEPT;
            elapsed_nxt = '0;
          end else begin
            state_nxt = PE_ERROR;
          end
        end else if (item.sop_is_sop && !is_data) begin
          case (state_r)
            PE_WAIT_ACCEPT: begin
              if (hdr_type == MT_ACCEPT) begin
                state_nxt   = PE_WAIT_PSRDY;
                elapsed_nxt = '0;
              end else if (hdr_type == MT_REJECT || hdr_type == MT_WAIT) begin
                state_nxt = PE_ERROR;
              end
            end
            PE_WAIT_PSRDY: begin
              if (hdr_type == MT_PS_RDY) begin
                volt_nxt  = volt_mv(pdo_r[19:10]);
                curr_nxt  = curr_ma(pdo_r[9:0]);
                state_nxt = PE_READY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_TICK: begin
        elapsed_nxt = elapsed_inc;
        if ((state_r == PE_WAIT_CAPS   && elapsed_inc >= caps_tmo_r) ||
            (state_r == PE_WAIT_ACCEPT && elapsed_inc >= resp_tmo_r) ||
            (state_r == PE_WAIT_PSRDY  && elapsed_inc >= ps_tmo_r)) begin
          state_nxt = PE_ERROR;
        end
      end
      default: begin
      end
    endcase
  end

  // Result word
  always_comb begin
    result.policy_state        = state_nxt;
    result.request_valid       = req_send;
    result.request_header      = req_send ? REQ_HEADER : 16'd0;
    result.request_object      = req_send ? fixed_rdo(item.first_object[9:0]) : 32'd0;
    result.contract_voltage_mv = volt_nxt;
    result.contract_current_ma = curr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= PE_IDLE;
      elapsed_r <= '0;
      pdo_r     <= '0;
      volt_r    <= '0;
      curr_r    <= '0;
    end else if (step_en) begin
      state_r   <= state_nxt;
      elapsed_r <= elapsed_nxt;
      pdo_r     <= pdo_nxt;
      volt_r    <= volt_nxt;
      curr_r    <= curr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_tmo_r <= WAIT_CAPS_TMO_RST;
      resp_tmo_r <= SENDER_RESP_TMO_RST;
      ps_tmo_r   <= PS_TRANS_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAIT_CAPS_TMO:   caps_tmo_r <= cfg_wdata;
        CFG_SENDER_RESP_TMO: resp_tmo_r <= cfg_wdata;
        CFG_PS_TRANS_TMO:    ps_tmo_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/usbpd_out_stage.sv =====
// ----------------------------------------------------------------------------
// usbpd_out_stage
// Result register: holds one result word until the master side takes it.
// ----------------------------------------------------------------------------
module usbpd_out_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  usbpd_pkg::result_t                 result,
  output logic                               out_free,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [usbpd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [usbpd_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import usbpd_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign out_free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = res_r.request_valid;
  assign out_tdata  = {7'd0,
                       res_r.contract_current_ma,
                       res_r.contract_voltage_mv,
                       res_r.request_object,
                       res_r.request_header,
                       res_r.policy_state};

endmodule

// ===== hdl/usb_pd_sink_policy_engine_top.sv =====
// ----------------------------------------------------------------------------
// usb_pd_sink_policy_engine_top
// USB PD sink policy engine: events in, one status/request word out per event.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream in_*: one event word each; in_tuser carries the operation
//   (attach, detach, received message, 1 ms tick), in_tdata the message.
//   Master stream out_*: exactly one result word per event, in order;
//   out_tuser flags a Request to transmit, out_tdata carries the policy
//   state, request header/object and the contract voltage and current.
//   cfg_*: timeout registers, written while no event is in flight.
// Path: an accepted event is held in the input register, then passes into
//   the result register, which drives out_tvalid, once that register is free.
// Throughput: one event per cycle unless the output stalls; the state update
//   is a single pass from the input register to the result register.
// Reset: rst_n (synchronous) empties both registers, puts the engine in idle
//   with no contract and reloads the default timeouts.
// Stall: the result register holds its word while out_tready is low; the
//   input register still takes one more event, then in_tready drops.
// ----------------------------------------------------------------------------
module usb_pd_sink_policy_engine_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] sop_is_sop, [16:1] header, [19:17] obj_count,
  // [51:20] first_object, [52] transmit_ok, [55:53] zero
  input  logic [usbpd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [1:0] operation
  input  logic [usbpd_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] policy_state, [18:3] request_header, [50:19] request_object,
  // [66:51] contract_voltage_mv, [80:67] contract_current_ma, [87:81] zero
  output logic [usbpd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] request_valid
  output logic [usbpd_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  logic                               cfg_we,
  input  logic [usbpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [usbpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import usbpd_pkg::*;

  item_t   item;
  result_t result;
  logic    item_vld;
  logic    out_free;
  logic    advance;

  // advance the held word into the result register
  assign advance = item_vld && out_free;

  usbpd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .item_vld  (item_vld),
    .item      (item)
  );

  usbpd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (advance),
    .item      (item),
    .result    (result)
  );

  usbpd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/usbpd_checker.sv =====
// ----------------------------------------------------------------------------
// usbpd_checker
// Port-level checks of the sink policy engine, bound to the top level.
// ----------------------------------------------------------------------------
module usbpd_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [usbpd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic [usbpd_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import usbpd_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a request word always leaves the engine waiting for Accept
  a_req_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[2:0] == PE_WAIT_ACCEPT && out_tdata[18:3] == REQ_HEADER)
    else $error("request word with wrong state or header");

  // no request: header and object are zero
  a_no_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[50:3] == 48'd0)
    else $error("request fields set without a request");

  // a contract is only reported in the ready state
  a_contract_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[66:51] != 16'd0 || out_tdata[80:67] != 14'd0) |->
      out_tdata[2:0] == PE_READY)
    else $error("contract reported outside ready");

endmodule

bind usb_pd_sink_policy_engine_top usbpd_checker u_usbpd_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the USB PD sink policy engine. A predictor in the
// testbench tracks the engine state, elapsed time, held PDO and contract for
// every accepted event word and queues the status word it should produce;
// a checker compares each result word field by field. Directed negotiation
// and timeout cases come first, then random negotiation sessions mixed with
// noise under several timeout settings, random idling and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import usbpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned PHASE_WORDS   = 265;
  localparam int unsigned MV_PER_STEP   = 50;
  localparam int unsigned MA_PER_STEP   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [15:0] REQ_HDR_WORD  = 16'h1082;
  localparam logic [31:0] RDO_BASE      = 32'h1300_0000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  usb_pd_sink_policy_engine_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the engine and its timeout registers
  policy_state_t pe_now   = PE_IDLE;
  logic [15:0] ms_count   = '0;
  logic [31:0] pdo_kept   = '0;
  logic [15:0] volt_kept  = '0;
  logic [13:0] curr_kept  = '0;
  logic [15:0] tmo_caps   = WAIT_CAPS_TMO_RST;
  logic [15:0] tmo_accept = SENDER_RESP_TMO_RST;
  logic [15:0] tmo_psrdy  = PS_TRANS_TMO_RST;

  result_t     status_q[$];
  int unsigned errors      = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold     = 0;
  bit          tx_idle     = 1'b0;
  bit          rx_idle     = 1'b0;

  function automatic void pe_clear();
    pe_now    = PE_IDLE;
    ms_count  = '0;
    pdo_kept  = '0;
    volt_kept = '0;
    curr_kept = '0;
  endfunction

  function automatic result_t pe_advance(input item_t w);
    result_t    r;
    logic [4:0] mtype;
    mtype = w.header[4:0];
    r = '0;
    case (w.operation)
      OP_ATTACH: begin
        pe_clear();
        pe_now = PE_WAIT_CAPS;
      end
      OP_DETACH: begin
        pe_clear();
      end
      OP_MESSAGE: begin
        if (w.sop_is_sop) begin
          // object count alone tells data from control
          if (w.obj_count != 3'd0) begin
            if (pe_now == PE_WAIT_CAPS && mtype == MT_SRC_CAPS) begin
              pdo_kept = w.first_object;
              if (pdo_kept[31:30] != 2'b00 || !w.transmit_ok) begin
                pe_now = PE_ERROR;
              end else begin
                r.request_valid  = 1'b1;
                r.request_header = REQ_HDR_WORD;
                r.request_object = RDO_BASE | (32'(pdo_kept[9:0]) << 10) |
                                   32'(pdo_kept[9:0]);
                pe_now   = PE_WAIT_ACCEPT;
                ms_count = '0;
              end
            end
          end else if (pe_now == PE_WAIT_ACCEPT) begin
            if (mtype == MT_ACCEPT) begin
              pe_now   = PE_WAIT_PSRDY;
              ms_count = '0;
            end else if (mtype == MT_REJECT || mtype == MT_WAIT) begin
              pe_now = PE_ERROR;
            end
          end else if (pe_now == PE_WAIT_PSRDY && mtype == MT_PS_RDY) begin
            volt_kept = 16'(pdo_kept[19:10] * MV_PER_STEP);
            curr_kept = 14'(pdo_kept[9:0] * MA_PER_STEP);
            pe_now    = PE_READY;
          end
        end
      end
      default: begin
        // saturating millisecond count, then the timeout of the waiting state
        if (ms_count != 16'hFFFF) ms_count++;
        if ((pe_now == PE_WAIT_CAPS   && ms_count >= tmo_caps)   ||
            (pe_now == PE_WAIT_ACCEPT && ms_count >= tmo_accept) ||
            (pe_now == PE_WAIT_PSRDY  && ms_count >= tmo_psrdy))
          pe_now = PE_ERROR;
      end
    endcase
    r.policy_state        = pe_now;
    r.contract_voltage_mv = volt_kept;
    r.contract_current_ma = curr_kept;
    return r;
  endfunction

  function automatic logic [15:0] hdr_of(input logic [4:0] mtype);
    logic [15:0] r;
    r = 16'($urandom);
    return {r[15:5], mtype};
  endfunction

  function automatic logic [31:0] fixed_pdo();
    return {2'b00, 30'($urandom)};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        $error("result word with no expected status pending");
        errors++;
      end else begin
        want = status_q.pop_front();
        check_field("policy_state", 32'(want.policy_state), 32'(out_tdata[2:0]));
        check_field("request_valid", 32'(want.request_valid), 32'(out_tuser[0]));
        check_field("request_header", 32'(want.request_header), 32'(out_tdata[18:3]));
        check_field("request_object", want.request_object, out_tdata[50:19]);
        check_field("contract_voltage_mv", 32'(want.contract_voltage_mv),
                    32'(out_tdata[66:51]));
        check_field("contract_current_ma", 32'(want.contract_current_ma),
                    32'(out_tdata[80:67]));
      end
    end
  end

  // Result receiver: random stalls, and a long hold when a test asks for one
  initial begin : rx_side
    int unsigned stall;
    forever begin
      if (rx_hold != 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(input op_t op, input logic sop, input logic [15:0] hdr,
                           input logic [2:0] cnt, input logic [31:0] obj,
                           input logic txok);
    item_t       w;
    int unsigned gap;
    w = '{operation: op, sop_is_sop: sop, header: hdr, obj_count: cnt,
          first_object: obj, transmit_ok: txok};
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.operation;
    in_tdata  <= {3'b000, w.transmit_ok, w.first_object, w.obj_count,
                  w.header, w.sop_is_sop};
    do @(posedge clk); while (!in_tready);
    status_q.push_back(pe_advance(w));
    words_sent++;
  endtask

  // Event with random content in the fields it does not use
  task automatic send_op(input op_t op);
    send_word(op, 1'($urandom), 16'($urandom), 3'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic send_msg(input logic [4:0] mtype, input logic [2:0] cnt,
                          input logic [31:0] obj, input logic txok);
    send_word(OP_MESSAGE, 1'b1, hdr_of(mtype), cnt, obj, txok);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WAIT_CAPS_TMO:   tmo_caps   = val;
      CFG_SENDER_RESP_TMO: tmo_accept = val;
      CFG_PS_TRANS_TMO:    tmo_psrdy  = val;
      default: ;
    endcase
  endtask

  task automatic set_timeouts(input logic [15:0] caps, input logic [15:0] accept,
                              input logic [15:0] psrdy);
    drain();
    write_reg(CFG_WAIT_CAPS_TMO, caps);
    write_reg(CFG_SENDER_RESP_TMO, accept);
    write_reg(CFG_PS_TRANS_TMO, psrdy);
  endtask

  // Mostly short tick runs, sometimes long ones, now and then a stray message
  task automatic tick_burst();
    int unsigned n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 2);
    repeat (n) send_op(OP_TICK);
    if ($urandom_range(0, 7) == 0)
      send_msg(5'($urandom), 3'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic run_session();
    int unsigned roll;
    logic [31:0] pdo;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 6))
        send_word(op_t'($urandom_range(0, 3)), 1'($urandom), 16'($urandom),
                  3'($urandom), $urandom, 1'($urandom));
      return;
    end
    send_op(OP_ATTACH);
    tick_burst();
    pdo = ($urandom_range(0, 9) < 8) ? fixed_pdo() : $urandom;
    if ($urandom_range(0, 9) == 0)
      send_word(OP_MESSAGE, 1'b0, hdr_of(MT_SRC_CAPS), 3'd1, fixed_pdo(), 1'b1);
    send_msg(MT_SRC_CAPS, 3'($urandom_range(1, 7)), pdo, $urandom_range(0, 9) != 0);
    tick_burst();
    roll = $urandom_range(0, 99);
    if (roll < 75)
      send_msg(MT_ACCEPT, 3'd0, $urandom, 1'($urandom));
    else if (roll < 85)
      send_msg(roll[0] ? MT_REJECT : MT_WAIT, 3'd0, $urandom, 1'($urandom));
    else
      send_msg(5'($urandom), 3'($urandom), $urandom, 1'($urandom));
    tick_burst();
    if ($urandom_range(0, 9) < 8) send_msg(MT_PS_RDY, 3'd0, $urandom, 1'($urandom));
    tick_burst();
    if ($urandom_range(0, 3) == 0) send_op(OP_DETACH);
  endtask

  task automatic test_negotiation();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_op(OP_TICK);
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);      // ignored while idle
    send_op(OP_ATTACH);
    send_word(OP_MESSAGE, 1'b0, hdr_of(MT_SRC_CAPS), 3'd1, fixed_pdo(), 1'b1);
    send_msg(MT_SRC_CAPS, 3'd0, fixed_pdo(), 1'b1);      // control, so ignored
    send_msg(MT_REQUEST, 3'd2, fixed_pdo(), 1'b1);
    send_msg(MT_SRC_CAPS, 3'd7, 32'h3FFF_FFFF, 1'b1);    // top voltage and current
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);
    send_msg(MT_PS_RDY, 3'd0, $urandom, 1'b1);
    send_op(OP_TICK);
    send_msg(MT_ACCEPT, 3'd0, $urandom, 1'b0);
    send_msg(MT_ACCEPT, 3'd0, $urandom, 1'b1);
    send_msg(MT_PS_RDY, 3'd0, $urandom, 1'b0);
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);      // ignored once ready
    send_op(OP_TICK);
    send_op(OP_DETACH);
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd1, {2'b01, 30'($urandom)}, 1'b1);
    send_msg(MT_ACCEPT, 3'd0, $urandom, 1'b1);           // ignored in error
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd2, fixed_pdo(), 1'b0);      // transmit refused
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd1, 32'h0000_0000, 1'b1);
    send_msg(MT_REJECT, 3'd0, $urandom, 1'b1);
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd1, {2'b11, 30'($urandom)}, 1'b1);
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);
    send_msg(MT_WAIT, 3'd0, $urandom, 1'b1);
    send_op(OP_DETACH);
  endtask

  task automatic test_timeouts();
    set_timeouts(16'd1, 16'd2, 16'd3);
    write_reg(CFG_SPARE_IDX, 16'd1);                     // unused index, no effect
    send_op(OP_ATTACH);
    send_op(OP_TICK);
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);
    repeat (2) send_op(OP_TICK);
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);
    send_op(OP_TICK);
    send_msg(MT_ACCEPT, 3'd0, $urandom, 1'b1);           // restarts the count
    repeat (3) send_op(OP_TICK);
    send_op(OP_ATTACH);
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);
    send_msg(MT_ACCEPT, 3'd0, $urandom, 1'b1);
    repeat (2) send_op(OP_TICK);
    send_msg(MT_PS_RDY, 3'd0, $urandom, 1'b1);
    send_op(OP_TICK);
  endtask

  task automatic test_backpressure();
    drain();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 80;
    repeat (4) run_session();
    drain();
  endtask

  task automatic test_random();
    int unsigned start;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_timeouts(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                        16'($urandom_range(1, 12)));
        1: set_timeouts(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                        16'($urandom_range(1, 40)));
        2: set_timeouts(16'd1, 16'd1, 16'd1);
        3: set_timeouts(WAIT_CAPS_TMO_RST, SENDER_RESP_TMO_RST, PS_TRANS_TMO_RST);
        4: set_timeouts(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                        16'($urandom_range(1, 6)));
        default: set_timeouts(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                              16'($urandom_range(1, 65535)));
      endcase
      tx_idle = (ph % 3) != 2;
      rx_idle = (ph % 2) == 0;
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) run_session();
    end
  endtask

  // Largest timeouts: a full negotiation with ticks in every waiting state
  task automatic test_max_timeout();
    set_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_op(OP_ATTACH);
    repeat (40) send_op(OP_TICK);
    send_msg(MT_SRC_CAPS, 3'd1, fixed_pdo(), 1'b1);
    repeat (40) send_op(OP_TICK);
    send_msg(MT_ACCEPT, 3'd0, $urandom, 1'b1);
    repeat (40) send_op(OP_TICK);
    send_msg(MT_PS_RDY, 3'd0, $urandom, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_negotiation();
    test_timeouts();
    test_backpressure();
    test_random();
    test_max_timeout();
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
